FILE: design/iad_pkg.sv
`timescale 1ns / 1ps

package iad_pkg;

    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 31;
    localparam int OUT_TDATA_W = ((CHAR_W + COUNT_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] C_ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] C_ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] C_ASCII_MINUS = 8'h2D;

endpackage

FILE: design/iad_front.sv
`timescale 1ns / 1ps

module iad_front
    import iad_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_is_signed,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VALUE_WIDTH:0]   o_job     // {neg, magnitude}
);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   r_neg;

    logic                   n_neg;
    logic [VALUE_WIDTH-1:0] n_mag;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = {r_neg, r_mag};

    // two's complement magnitude; the most negative value maps onto itself
    always_comb begin
        n_neg = i_is_signed & i_value[VALUE_WIDTH-1];
        n_mag = n_neg ? (~i_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
    end

endmodule

FILE: design/iad_fifo.sv
`timescale 1ns / 1ps

module iad_fifo #(
    parameter int DATA_W = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_fill;

    logic push;
    logic pop;

    assign o_ready = (r_fill != 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
    end

endmodule

FILE: design/iad_back.sv
`timescale 1ns / 1ps

module iad_back
    import iad_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_WIDTH:0] i_job,   // {neg, magnitude}
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CHAR_W-1:0]  o_char,
    output logic               o_last,
    output logic [COUNT_W-1:0] o_count
);

    localparam int ND    = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int IDX_W = $clog2(ND);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_FIND  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_bin;
    logic [ND*4-1:0]        r_bcd;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic [IDX_W-1:0]       r_idx;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_ovalid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;
    logic [COUNT_W-1:0]     r_ocount;

    logic [ND*4-1:0]        adj;
    logic [IDX_W-1:0]       n_idx;
    logic [COUNT_W-1:0]     n_count;
    logic [3:0]             digit;
    logic                   out_free;
    logic                   emit;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_char   = r_char;
    assign o_last   = r_last;
    assign o_count  = r_ocount;
    assign out_free = !r_ovalid || i_ready;
    assign emit     = out_free && ((r_state == S_SIGN) || (r_state == S_DIGIT));
    assign digit    = r_bcd[{r_idx, 2'b00} +: 4];
    assign n_count  = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    // add-3 on every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] d;
        for (int i = 0; i < ND; i++) begin
            d = r_bcd[i*4 +: 4];
            adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // highest non-zero digit; zero gives the units digit
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < ND; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) n_idx = IDX_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) r_ovalid <= emit;
            if (emit)     r_count  <= n_count;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_CONV;
                end
                S_CONV: begin
                    if (r_cnt == '0) r_state <= S_FIND;
                end
                S_FIND: begin
                    r_state <= r_neg ? S_SIGN : S_DIGIT;
                end
                S_SIGN: begin
                    if (out_free) r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    if (out_free && r_idx == '0) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_bin <= i_job[VALUE_WIDTH-1:0];
                    r_neg <= i_job[VALUE_WIDTH];
                    r_bcd <= '0;
                    r_cnt <= CNT_W'(VALUE_WIDTH - 1);
                end
            end
            S_CONV: begin
                r_bcd <= {adj[ND*4-2:0], r_bin[VALUE_WIDTH-1]};
                r_bin <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIND: begin
                r_idx <= n_idx;
            end
            S_SIGN: begin
                if (out_free) begin
                    r_char   <= C_ASCII_MINUS;
                    r_last   <= 1'b0;
                    r_ocount <= n_count;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    r_char   <= C_ASCII_ZERO + {4'd0, digit};
                    r_last   <= (r_idx == '0);
                    r_ocount <= n_count;
                    r_idx    <= r_idx - 1'b1;
                end
            end
            default: ;
        endcase
    end

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("character count went backwards");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_char == C_ASCII_MINUS) |-> !r_last)
        else $error("sign word flagged as last");

    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_last) |-> (r_char >= C_ASCII_ZERO && r_char <= C_ASCII_NINE))
        else $error("last word is not a digit");

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> r_ocount == r_count)
        else $error("word count out of step with counter");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> $past(r_state == S_IDLE || r_state == S_CONV))
        else $error("conversion entered from wrong state");

endmodule

FILE: design/int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Channel  Dir  Ports              Word
// s        in   i_s_*/o_s_tready   tdata: value; tuser: is_signed
// m        out  o_m_*/i_m_tready   tdata: ascii_char, running_count; tlast: last_char
//
// Per number: the front register, then the queue, then in the back a load step,
// a shift-and-add-3 step for each value bit, a step to locate the leading digit
// and one character per cycle unless the output stalls (up to 11 at the default width).
// A 2-deep queue sits between front and back; the front keeps taking words
// while the back converts or waits on the output. Reset is synchronous, low.
// A stalled output register holds the back; the queue then fills and o_s_tready drops.

module int_to_decimal_ascii
    import iad_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       i_s_tdata,  // value
    input  logic                                   i_s_tuser,  // is_signed
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]                 o_m_tdata,  // ascii_char, running_count, pad
    output logic                                   o_m_tlast   // last_char
);

    logic                   front_valid;
    logic                   front_ready;
    logic [VALUE_WIDTH:0]   front_job;
    logic                   q_valid;
    logic                   q_ready;
    logic [VALUE_WIDTH:0]   q_job;
    logic [CHAR_W-1:0]      out_char;
    logic [COUNT_W-1:0]     out_count;

    iad_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_value     (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_is_signed (i_s_tuser),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_job       (front_job)
    );

    iad_fifo #(.DATA_W(VALUE_WIDTH + 1)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_job)
    );

    iad_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_char  (out_char),
        .o_last  (o_m_tlast),
        .o_count (out_count)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - CHAR_W - COUNT_W){1'b0}}, out_count, out_char};

endmodule
